// ----- rtl/core/cvfc_pkg.sv -----
`default_nettype none

package cvfc_pkg;

    localparam int ValueW      = 64;
    localparam int PosW        = 6;
    localparam int C16MantW    = 13;
    localparam int C16ExpStep  = 3;
    localparam int C16ExpW     = 5;
    localparam int C16ExpMax   = 7;
    localparam int C16W        = 16;
    localparam int C16StepMax  = (ValueW - C16MantW + C16ExpStep - 1) / C16ExpStep;
    localparam int C24MantW    = 20;
    localparam int C24ExpW     = 6;
    localparam int C24ExpMax   = 31;
    localparam int C24W        = 24;
    localparam int FltExpTop   = 190;
    localparam int FltMantShift = 40;
    localparam int FltMantW    = 23;
    localparam int FltExpW     = 8;
    localparam int FltW        = 32;

    typedef struct packed {
        logic [ValueW-1:0] value;
        logic [PosW-1:0]   pos;
        logic              zero;
    } cvfc_s1_t;

    typedef struct packed {
        logic [C16MantW-1:0] m16;
        logic                up16;
        logic [C16ExpW-1:0]  e16;
        logic [C24MantW-1:0] m24;
        logic                up24;
        logic [C24ExpW-1:0]  e24;
        logic [FltExpW-1:0]  fexp;
        logic [FltMantW-1:0] fmant;
        logic                zero;
    } cvfc_s2_t;

    typedef struct packed {
        logic [C16W-1:0] code16;
        logic            code16_saturated;
        logic [C24W-1:0] code24;
        logic            code24_saturated;
        logic [FltW-1:0] float_bits;
    } cvfc_res_t;

    // Number of base-8 steps needed to bring a value whose leading one sits at
    // pos down into the 13-bit mantissa.
    function automatic logic [C16ExpW-1:0] c16_steps(input logic [PosW-1:0] pos);
        logic [C16ExpW-1:0] k;
        k = '0;
        for (int j = 1; j <= C16StepMax; j++)
        begin
            if ({1'b0, pos} >= (PosW+1)'(C16MantW + C16ExpStep * (j - 1)))
            begin
                k = k + C16ExpW'(1);
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cvfc_in_if.sv -----
`default_nettype none

interface cvfc_in_if;
    import cvfc_pkg::*;

    logic              valid;
    logic              ready;
    logic [ValueW-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cvfc_out_if.sv -----
`default_nettype none

interface cvfc_out_if;
    import cvfc_pkg::*;

    logic            valid;
    logic            ready;
    logic [C16W-1:0] code16;
    logic            code16_saturated;
    logic [C24W-1:0] code24;
    logic            code24_saturated;
    logic [FltW-1:0] float_bits;

    modport source (output valid, output code16, output code16_saturated, output code24,
                    output code24_saturated, output float_bits, input ready);
    modport sink (input valid, input code16, input code16_saturated, input code24,
                  input code24_saturated, input float_bits, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cvfc_msb.sv -----
`default_nettype none

// Leading-one detector: each byte is encoded on its own, then the highest
// nonzero byte is chosen.
module cvfc_msb (
    input  wire logic [cvfc_pkg::ValueW-1:0] value,
    output logic [cvfc_pkg::PosW-1:0]        pos,
    output logic                             zero
);
    import cvfc_pkg::*;

    localparam int Bytes = ValueW / 8;

    logic [Bytes-1:0] byte_any;
    logic [2:0]       byte_pos [Bytes];

    always_comb
    begin
        for (int b = 0; b < Bytes; b++)
        begin
            byte_any[b] = |value[b*8 +: 8];
            byte_pos[b] = 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                if (value[b*8 + i])
                begin
                    byte_pos[b] = 3'(i);
                end
            end
        end
    end

    always_comb
    begin
        pos = '0;
        for (int b = 0; b < Bytes; b++)
        begin
            if (byte_any[b])
            begin
                pos = {3'(b), byte_pos[b]};
            end
        end
        zero = ~|byte_any;
    end

endmodule

`default_nettype wire

// ----- rtl/core/counter_value_float_compressor_top.sv -----
// Counter value compressor, three register stages.
// Throughput: one item per cycle while the output accepts results; the stages
// are leading-one detection, barrel shifting, and rounding with packing into
// the output register.
// Reset (rst_n, asynchronous, active low) clears the stage valid bits only.
`default_nettype none

module counter_value_float_compressor_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cvfc_in_if.sink    sample,
    cvfc_out_if.source result
);
    import cvfc_pkg::*;

    logic      v1_reg, v2_reg, v3_reg;
    logic      en1, en2, en3;
    cvfc_s1_t  s1_reg, s1_next;
    cvfc_s2_t  s2_reg, s2_next;
    cvfc_res_t s3_reg, s3_next;

    logic [PosW-1:0] msb_pos;
    logic            msb_zero;

    // A stage loads when it is empty or its contents move on this cycle.
    assign en3 = !v3_reg || result.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign sample.ready = en1;

    cvfc_msb u_msb (
        .value (sample.value),
        .pos   (msb_pos),
        .zero  (msb_zero)
    );

    always_comb
    begin
        s1_next.value = sample.value;
        s1_next.pos   = msb_pos;
        s1_next.zero  = msb_zero;
    end

    // Stage 2: shift every code into its mantissa window; for the 16- and 24-bit
    // codes the bit just below the window is carried along as the rounding bit.
    logic [C16ExpW-1:0] k16;
    logic [PosW-1:0]    sh16;
    logic [PosW-1:0]    k24;
    logic [ValueW:0]    t16;
    logic [ValueW:0]    t24;
    logic [ValueW-1:0]  fnorm;

    always_comb
    begin
        k16  = c16_steps(s1_reg.pos);
        sh16 = ({1'b0, k16} << 1) + {1'b0, k16};
        k24  = (s1_reg.pos > PosW'(C24MantW - 1)) ? s1_reg.pos - PosW'(C24MantW - 1) : '0;
        t16  = {s1_reg.value, 1'b0} >> sh16;
        t24  = {s1_reg.value, 1'b0} >> k24;
        fnorm = s1_reg.value << (PosW'(ValueW - 1) - s1_reg.pos);

        s2_next.m16   = t16[C16MantW:1];
        s2_next.up16  = t16[0];
        s2_next.e16   = k16;
        s2_next.m24   = t24[C24MantW:1];
        s2_next.up24  = t24[0];
        s2_next.e24   = (s1_reg.pos >= PosW'(C24MantW - 1))
                      ? C24ExpW'(s1_reg.pos - PosW'(C24MantW - 2)) : '0;
        s2_next.fexp  = FltExpW'(FltExpTop - (ValueW - 1)) + FltExpW'(s1_reg.pos);
        s2_next.fmant = fnorm[FltMantShift +: FltMantW];
        s2_next.zero  = s1_reg.zero;
    end

    // Stage 3: round, handle the carry out of the mantissa, saturate, pack.
    logic [C16MantW:0]   sum16;
    logic [C16MantW-1:0] mant16;
    logic [C16ExpW-1:0]  exp16;
    logic                sat16;
    logic [C24MantW:0]   sum24;
    logic [C24MantW-1:0] mant24;
    logic [C24ExpW-1:0]  exp24;
    logic                sat24;

    always_comb
    begin
        sum16  = {1'b0, s2_reg.m16} + (C16MantW+1)'(s2_reg.up16);
        mant16 = sum16[C16MantW] ? C16MantW'(1 << (C16MantW - C16ExpStep))
                                 : sum16[C16MantW-1:0];
        exp16  = s2_reg.e16 + C16ExpW'(sum16[C16MantW]);
        sat16  = exp16 > C16ExpW'(C16ExpMax);

        sum24  = {1'b0, s2_reg.m24} + (C24MantW+1)'(s2_reg.up24);
        mant24 = sum24[C24MantW] ? C24MantW'(1 << (C24MantW - 1)) : sum24[C24MantW-1:0];
        exp24  = s2_reg.e24 + C24ExpW'(sum24[C24MantW]);
        sat24  = exp24 > C24ExpW'(C24ExpMax);

        s3_next.code16           = sat16 ? '1 : {exp16[C16W-C16MantW-1:0], mant16};
        s3_next.code16_saturated = sat16;
        s3_next.code24           = sat24 ? '1
                                 : {exp24[C24W-C24MantW:0], mant24[C24MantW-2:0]};
        s3_next.code24_saturated = sat24;
        s3_next.float_bits       = s2_reg.zero ? '0 : {1'b0, s2_reg.fexp, s2_reg.fmant};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= sample.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s1_next;
        end
        if (en2)
        begin
            s2_reg <= s2_next;
        end
        if (en3)
        begin
            s3_reg <= s3_next;
        end
    end

    assign result.valid            = v3_reg;
    assign result.code16           = s3_reg.code16;
    assign result.code16_saturated = s3_reg.code16_saturated;
    assign result.code24           = s3_reg.code24;
    assign result.code24_saturated = s3_reg.code24_saturated;
    assign result.float_bits       = s3_reg.float_bits;

    // Back-pressure reaches the input only when every stage holds an item.
    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (v1_reg && v2_reg && v3_reg))
        else $error("input stalled while a stage is empty");

    // An item in stage 2 that moves on shows up at the output next cycle.
    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && en3) |=> result.valid)
        else $error("item lost between stage 2 and the output");

    // A zero count gives zero in all three codes.
    a_zero_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.float_bits == '0) |->
        (result.code16 == '0 && result.code24 == '0
         && !result.code16_saturated && !result.code24_saturated))
        else $error("zero value coded inconsistently");

    // The 24-bit code saturates only where the 16-bit code already has.
    a_sat_order: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.code24_saturated) |-> result.code16_saturated)
        else $error("24-bit code saturated below the 16-bit range");

endmodule

`default_nettype wire
